[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Simulation builds get concurrent assertions. Synthesis builds get nothing.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// An implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/hbpt_pkg.sv]
// ---------------------------------------------------------------------------
// hbpt_pkg
// Shared types, constants and helpers for the histogram with peak tracking.
// ---------------------------------------------------------------------------
package hbpt_pkg;

    // Sizes of the bin store and of the data path.
    localparam int MAX_BINS   = 1024;
    localparam int BIN_W      = $clog2(MAX_BINS);
    localparam int COUNT_W    = 32;
    localparam int DATA_W     = 32;
    localparam int CFG_BINS_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int DSR_W      = DATA_W + BIN_W;
    localparam int LIMIT_W    = DATA_W + CFG_BINS_W;
    localparam int STEP_W     = (BIN_W > 1) ? $clog2(BIN_W) : 1;

    localparam logic [COUNT_W-1:0]    COUNT_MAX        = {COUNT_W{1'b1}};
    localparam logic [DATA_W-1:0]     RESET_RANGE_LOW  = '0;
    localparam logic [DATA_W-1:0]     RESET_BIN_WIDTH  = DATA_W'(65536);
    localparam logic [CFG_BINS_W-1:0] RESET_BINS       = CFG_BINS_W'(1024);
    localparam logic [CFG_BINS_W-1:0] MAX_BINS_CFG     = CFG_BINS_W'(MAX_BINS);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_LOW   = 2'd0,
        CFG_BIN_WIDTH   = 2'd1,
        CFG_BINS_IN_USE = 2'd2
    } t_cfg_idx;

    // Front end states.
    typedef enum logic [1:0] {
        F_IDLE,
        F_CHECK,
        F_DIV,
        F_PUSH
    } t_front_state;

    // Back end states.
    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_UPDATE
    } t_back_state;

    // One classified sample travelling from front to back.
    typedef struct packed {
        logic             hit;
        logic [BIN_W-1:0] idx;
    } t_req;

    // Increment that holds at the top of the count range.
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

[src/histogram_bin_with_peak_track.sv]
// ---------------------------------------------------------------------------
// histogram_bin_with_peak_track
// Histogram of signed Q16.16 samples with running peak (mode) and total.
//
//   Channel   Handshake                      Payload
//   sample    i_sample_valid/o_sample_ready  i_sample_value
//   result    o_res_valid/i_res_ready        o_in_range .. o_total_counted
//   config    i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// An in-range sample passes through the front end in capture, span check,
// ten division steps and hand-over; a dropped sample skips the division.
// For each counted sample the back end reads the bin store in its idle
// state and writes it back in the update state, so the front-end divider
// sets the rate. After reset all 1024 bins of the store are cleared, during
// which no sample is accepted; configuration writes are taken at all times.
// A stalled result holds the back end; the two-entry queue lets the front
// end carry on until it fills.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module histogram_bin_with_peak_track
    import hbpt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_sample_valid,
    output logic                 o_sample_ready,
    input  logic [DATA_W-1:0]    i_sample_value,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output logic                 o_in_range,
    output logic [BIN_W-1:0]     o_bin_index,
    output logic [COUNT_W-1:0]   o_bin_count_now,
    output logic [COUNT_W-1:0]   o_peak_count,
    output logic [BIN_W-1:0]     o_peak_index,
    output logic [COUNT_W-1:0]   o_total_counted,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    logic [DATA_W-1:0]     r_range_low;
    logic [DATA_W-1:0]     r_bin_width;
    logic [CFG_BINS_W-1:0] r_bins_in_use;

    logic clearing;
    logic push_valid;
    logic q_not_full;
    t_req push_data;
    logic q_not_empty;
    logic q_pop;
    t_req q_data;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low   <= RESET_RANGE_LOW;
            r_bin_width   <= RESET_BIN_WIDTH;
            r_bins_in_use <= RESET_BINS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RANGE_LOW:   r_range_low   <= i_cfg_data;
                CFG_BIN_WIDTH:   r_bin_width   <= i_cfg_data;
                CFG_BINS_IN_USE: r_bins_in_use <= i_cfg_data[CFG_BINS_W-1:0];
                default:         r_range_low   <= r_range_low;
            endcase
        end
    end

    // Front end: span check and bin division.
    hbpt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enable       (!clearing),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample_value (i_sample_value),
        .i_range_low    (r_range_low),
        .i_bin_width    (r_bin_width),
        .i_bins_in_use  (r_bins_in_use),
        .o_push_valid   (push_valid),
        .i_push_ready   (q_not_full),
        .o_push_data    (push_data)
    );

    // Queue between front and back ends.
    hbpt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_valid),
        .i_push_data (push_data),
        .o_not_full  (q_not_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_pop_data  (q_data)
    );

    // Back end: bin store update, peak and total tracking.
    hbpt_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .o_clearing      (clearing),
        .i_q_not_empty   (q_not_empty),
        .i_q_data        (q_data),
        .o_q_pop         (q_pop),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_in_range      (o_in_range),
        .o_bin_index     (o_bin_index),
        .o_bin_count_now (o_bin_count_now),
        .o_peak_count    (o_peak_count),
        .o_peak_index    (o_peak_index),
        .o_total_counted (o_total_counted)
    );

    // No sample is taken while the bin store is being cleared.
    `ASSERT_ALWAYS(a_no_accept_clear, i_clk, i_rst_n, !(clearing && o_sample_ready))

    // A dropped sample reports bin zero with a zero count.
    `ASSERT_ALWAYS(a_drop_zero, i_clk, i_rst_n, !(o_res_valid && !o_in_range) || (o_bin_index == '0 && o_bin_count_now == '0))

    // The peak is never below the count of the bin just updated.
    `ASSERT_ALWAYS(a_peak_covers, i_clk, i_rst_n, !(o_res_valid && o_in_range) || (o_peak_count >= o_bin_count_now))

    // The total never falls below the peak count.
    `ASSERT_ALWAYS(a_total_covers, i_clk, i_rst_n, o_total_counted >= o_peak_count)

    // A hit popped from the queue is followed by the update state.
    `ASSERT_NEXT(a_hit_update, i_clk, i_rst_n, q_pop && q_data.hit, !q_pop)

endmodule

[src/hbpt_front.sv]
// ---------------------------------------------------------------------------
// hbpt_front
// Accepts samples, checks them against the configured span and finds the
// bin by restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module hbpt_front
    import hbpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_enable,
    input  logic                  i_sample_valid,
    output logic                  o_sample_ready,
    input  logic [DATA_W-1:0]     i_sample_value,
    input  logic [DATA_W-1:0]     i_range_low,
    input  logic [DATA_W-1:0]     i_bin_width,
    input  logic [CFG_BINS_W-1:0] i_bins_in_use,
    output logic                  o_push_valid,
    input  logic                  i_push_ready,
    output t_req                  o_push_data
);

    t_front_state r_state, n_state;

    logic [DATA_W:0]       r_diff;
    logic [DATA_W-1:0]     r_rem;
    logic [DSR_W-1:0]      r_dsr;
    logic [BIN_W-1:0]      r_quo;
    logic [STEP_W-1:0]     r_step;
    logic                  r_hit;

    logic [CFG_BINS_W-1:0] nbins;
    logic [LIMIT_W-1:0]    limit;
    logic                  span_hit;
    logic                  div_ge;
    logic                  accept;
    logic                  last_step;

    // Span check: the sample lies in [low, low + nbins * width).
    assign nbins    = (i_bins_in_use > MAX_BINS_CFG) ? MAX_BINS_CFG : i_bins_in_use;
    assign limit    = LIMIT_W'(nbins) * LIMIT_W'(i_bin_width);
    assign span_hit = (i_bin_width != '0) && !r_diff[DATA_W]
                      && (LIMIT_W'(r_diff[DATA_W-1:0]) < limit);

    // One restoring division step.
    assign div_ge    = (DSR_W'(r_rem) >= r_dsr);
    assign last_step = (r_step == STEP_W'(BIN_W - 1));

    assign accept = i_sample_valid && o_sample_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (accept) n_state = F_CHECK;
            F_CHECK: n_state = span_hit ? F_DIV : F_PUSH;
            F_DIV:   if (last_step) n_state = F_PUSH;
            F_PUSH:  if (i_push_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_sample_ready    = 1'b0;
        o_push_valid      = 1'b0;
        o_push_data.hit   = r_hit;
        o_push_data.idx   = r_hit ? r_quo : '0;
        case (r_state)
            F_IDLE:  o_sample_ready = i_enable;
            F_PUSH:  o_push_valid   = 1'b1;
            default: begin
                o_sample_ready = 1'b0;
                o_push_valid   = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    r_diff <= {i_sample_value[DATA_W-1], i_sample_value}
                              - {i_range_low[DATA_W-1], i_range_low};
                end
            end
            F_CHECK: begin
                r_hit  <= span_hit;
                r_rem  <= r_diff[DATA_W-1:0];
                r_dsr  <= DSR_W'(i_bin_width) << (BIN_W - 1);
                r_quo  <= '0;
                r_step <= '0;
            end
            F_DIV: begin
                if (div_ge) begin
                    r_rem <= r_rem - r_dsr[DATA_W-1:0];
                end
                r_quo  <= {r_quo[BIN_W-2:0], div_ge};
                r_dsr  <= r_dsr >> 1;
                r_step <= r_step + STEP_W'(1);
            end
            default: begin
                r_hit <= r_hit;
            end
        endcase
    end

endmodule

[src/hbpt_queue.sv]
// ---------------------------------------------------------------------------
// hbpt_queue
// Two-entry queue between the front and back ends.
// ---------------------------------------------------------------------------
module hbpt_queue
    import hbpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_push_data,
    output logic o_not_full,
    input  logic i_pop,
    output logic o_not_empty,
    output t_req o_pop_data
);

    t_req       r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_not_full  = (r_count != 2'd2);
    assign o_not_empty = (r_count != 2'd0);
    assign o_pop_data  = r_entry[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push && o_not_full) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop && o_not_empty) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push && o_not_full, i_pop && o_not_empty})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push && o_not_full) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[src/hbpt_back.sv]
// ---------------------------------------------------------------------------
// hbpt_back
// Holds the bin store, clears it after reset, performs the read-modify-write
// of each counted sample, tracks the peak and total, and holds the result.
// ---------------------------------------------------------------------------
module hbpt_back
    import hbpt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    output logic               o_clearing,
    input  logic               i_q_not_empty,
    input  t_req               i_q_data,
    output logic               o_q_pop,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic               o_in_range,
    output logic [BIN_W-1:0]   o_bin_index,
    output logic [COUNT_W-1:0] o_bin_count_now,
    output logic [COUNT_W-1:0] o_peak_count,
    output logic [BIN_W-1:0]   o_peak_index,
    output logic [COUNT_W-1:0] o_total_counted
);

    t_back_state r_state, n_state;

    logic [COUNT_W-1:0] mem [MAX_BINS];
    logic [COUNT_W-1:0] r_rd_data;
    logic [BIN_W-1:0]   r_idx;
    logic [BIN_W-1:0]   r_clr_addr;

    logic [COUNT_W-1:0] r_peak_count;
    logic [BIN_W-1:0]   r_peak_index;
    logic [COUNT_W-1:0] r_total;

    logic               r_o_valid;
    logic               r_o_in_range;
    logic [BIN_W-1:0]   r_o_bin_index;
    logic [COUNT_W-1:0] r_o_bin_count;

    logic               out_free;
    logic               rd_en;
    logic               wr_en;
    logic [BIN_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic [COUNT_W-1:0] new_count;
    logic               take_miss;
    logic               do_update;
    logic               clr_last;

    assign out_free  = !r_o_valid || i_res_ready;
    assign new_count = sat_inc(r_rd_data);
    assign clr_last  = (r_clr_addr == BIN_W'(MAX_BINS - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_CLEAR:  if (clr_last) n_state = B_IDLE;
            B_IDLE:   if (i_q_not_empty && i_q_data.hit) n_state = B_UPDATE;
            B_UPDATE: if (out_free) n_state = B_IDLE;
            default:  n_state = B_CLEAR;
        endcase
    end

    // Control outputs: queue pops, memory port, result load.
    always_comb begin
        o_clearing = 1'b0;
        o_q_pop    = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_idx;
        wr_data    = new_count;
        take_miss  = 1'b0;
        do_update  = 1'b0;
        case (r_state)
            B_CLEAR: begin
                o_clearing = 1'b1;
                wr_en      = 1'b1;
                wr_addr    = r_clr_addr;
                wr_data    = '0;
            end
            B_IDLE: begin
                if (i_q_not_empty) begin
                    if (i_q_data.hit) begin
                        o_q_pop = 1'b1;
                        rd_en   = 1'b1;
                    end else if (out_free) begin
                        o_q_pop   = 1'b1;
                        take_miss = 1'b1;
                    end
                end
            end
            B_UPDATE: begin
                if (out_free) begin
                    wr_en     = 1'b1;
                    do_update = 1'b1;
                end
            end
            default: begin
                o_clearing = 1'b0;
            end
        endcase
    end

    // State register and clear address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLEAR) begin
                r_clr_addr <= r_clr_addr + BIN_W'(1);
            end
        end
    end

    // Bin store with a registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[i_q_data.idx];
            r_idx     <= i_q_data.idx;
        end
    end

    // Peak, total and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak_count <= '0;
            r_peak_index <= '0;
            r_total      <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (do_update) begin
                r_total <= sat_inc(r_total);
                if (new_count >= r_peak_count) begin
                    r_peak_count <= new_count;
                    r_peak_index <= r_idx;
                end
            end
            if (do_update || take_miss) begin
                r_o_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (do_update) begin
            r_o_in_range  <= 1'b1;
            r_o_bin_index <= r_idx;
            r_o_bin_count <= new_count;
        end else if (take_miss) begin
            r_o_in_range  <= 1'b0;
            r_o_bin_index <= '0;
            r_o_bin_count <= '0;
        end
    end

    assign o_res_valid     = r_o_valid;
    assign o_in_range      = r_o_in_range;
    assign o_bin_index     = r_o_bin_index;
    assign o_bin_count_now = r_o_bin_count;
    assign o_peak_count    = r_peak_count;
    assign o_peak_index    = r_peak_index;
    assign o_total_counted = r_total;

endmodule
